@@ rtl/core/b64u_pkg.sv @@
// Shared types, phase codes and alphabet lookup for the base64url stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64u_pkg;

  // Position of the next byte within its three-byte group
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } b64u_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_message;
  } b64u_out_t;

  // One or two characters produced by one byte
  typedef struct packed {
    logic [6:0] char0;
    logic       last0;
    logic [6:0] char1;
    logic       last1;
    logic       two;
  } b64u_pair_t;

  // Map a sextet to its ASCII code: A-Z a-z 0-9 - _
  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] sx);
    logic [6:0] code;
    code = 7'h5F;
    case (sx) inside
      [6'd0:6'd25]:  code = 7'(sx) + 7'h41;
      [6'd26:6'd51]: code = 7'(sx) + 7'h47;
      [6'd52:6'd61]: code = 7'(sx) - 7'h04;
      6'd62:         code = 7'h2D;
      default:       code = 7'h5F;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/base64url_stream_encoder.sv @@
// Top level of the unpadded base64url stream encoder.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_i  (data_byte, is_final)
//  out     | output    | out_valid_o/out_stall_i | out_o (out_char, end_of_message)
//
// Flow: a byte yields one character or a pair; the single result register sends them
//   one character per cycle while out_stall_i is low, and takes the next byte once it
//   is empty or its last character leaves. A byte passes the input, then result register.
// Reset: rst_ni clears the group phase, the carry bits and all valid flags at once.
// Stalls: out_stall_i holds the current character; the input register still takes a
//   byte while the result register waits, then stalls until the pair is free.
`timescale 1ns / 1ps
`default_nettype none

module base64url_stream_encoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire b64u_pkg::b64u_in_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output b64u_pkg::b64u_out_t      out_o
);
  import b64u_pkg::*;

  // input register
  logic       in_vld_q;
  b64u_in_t   in_item_q;

  logic       buf_free;
  logic       advance;
  b64u_pair_t pair;

  // move the held item into the result register whenever that register frees up
  assign advance    = in_vld_q && buf_free;
  // hold the input item while it cannot move on
  assign in_stall_o = in_vld_q && !buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_i;
    end
  end

  // split the byte into characters, advance phase and carry on hand-off
  b64u_sextet u_sextet (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_item_q),
    .advance_i (advance),
    .pair_o    (pair)
  );

  // send the pair one item per cycle while out_stall_i is low
  b64u_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .pair_i      (pair),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/b64u_sextet.sv @@
// Group phase and carry state, and the split of one byte into one or two characters.
`timescale 1ns / 1ps
`default_nettype none

module b64u_sextet (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire b64u_pkg::b64u_in_t  item_i,
  input  wire logic                advance_i,
  output b64u_pkg::b64u_pair_t     pair_o
);
  import b64u_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [5:0] sx0, sx1;
  logic [7:0] b;

  assign b = item_i.data_byte;

  always_comb begin
    pair_o  = '0;
    sx0     = b[7:2];
    sx1     = {b[1:0], 4'b0000};
    phase_d = PH_1;
    carry_d = {2'b00, b[1:0]};
    pair_o.two   = item_i.is_final;
    pair_o.last1 = 1'b1;
    case (phase_q)
      PH_1: begin
        sx0     = {carry_q[1:0], b[7:4]};
        sx1     = {b[3:0], 2'b00};
        phase_d = PH_2;
        carry_d = b[3:0];
      end
      PH_2: begin
        sx0     = {carry_q, b[7:6]};
        sx1     = b[5:0];
        phase_d = PH_0;
        carry_d = 4'd0;
        pair_o.two   = 1'b1;
        pair_o.last1 = item_i.is_final;
      end
      default: begin
        // phase zero, and the unreachable fourth code, split the same way
      end
    endcase
    // a final byte closes the message: start the next one clean
    if (item_i.is_final) begin
      phase_d = PH_0;
      carry_d = 4'd0;
    end
    pair_o.char0 = sextet_to_ascii(sx0);
    pair_o.char1 = sextet_to_ascii(sx1);
    pair_o.last0 = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      carry_q <= 4'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64u_out_buf.sv @@
// Result register holding one character pair and sending it one item at a time.
`timescale 1ns / 1ps
`default_nettype none

module b64u_out_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire b64u_pkg::b64u_pair_t  pair_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output b64u_pkg::b64u_out_t        out_o
);
  import b64u_pkg::*;

  b64u_pair_t pair_q;
  logic       vld_q;
  logic       sel_q;
  logic       take;

  assign take        = vld_q && !out_stall_i;
  assign free_o      = !vld_q || (take && (!pair_q.two || sel_q));
  assign out_valid_o = vld_q;

  always_comb begin
    if (sel_q) begin
      out_o.out_char       = pair_q.char1;
      out_o.end_of_message = pair_q.last1;
    end else begin
      out_o.out_char       = pair_q.char0;
      out_o.end_of_message = pair_q.last0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      sel_q <= 1'b0;
    end else if (take) begin
      if (pair_q.two && !sel_q) begin
        sel_q <= 1'b1;
      end else begin
        vld_q <= 1'b0;
        sel_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64u_checker.sv @@
// Port-level checks for the base64url stream encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module b64u_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire b64u_pkg::b64u_out_t out_o
);
  import b64u_pkg::*;

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("output item changed while stalled");

  // only alphabet characters leave the block
  a_alphabet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_o.out_char >= 7'h41 && out_o.out_char <= 7'h5A) ||
      (out_o.out_char >= 7'h61 && out_o.out_char <= 7'h7A) ||
      (out_o.out_char >= 7'h30 && out_o.out_char <= 7'h39) ||
      out_o.out_char == 7'h2D || out_o.out_char == 7'h5F)
    else $error("output character outside the base64url alphabet");

  // the input only waits behind pending output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  // output appears only after an accepted byte has passed the input and result registers
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output item without an accepted byte");

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

`default_nettype wire
